[design/assert_macros.svh]
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("invariant check failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)

`endif

`endif

[design/osl_pkg.sv]
package osl_pkg;

  localparam int RANGE_BITS = 14;
  localparam int CMD_BITS   = 16;
  localparam int SCALE_BITS = 16;
  localparam int QUO_BITS   = SCALE_BITS - 1;
  localparam int REM_BITS   = RANGE_BITS + 1;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = QUO_BITS / DIV_STEPS;
  localparam int LATENCY    = DIV_STAGES + 3;
  localparam int MUL_BITS   = CMD_BITS - 1 + QUO_BITS;

  localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << QUO_BITS;

  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  typedef enum logic [0:0] {
    REG_STOP_DIST = 1'b0,
    REG_SLOW_DIST = 1'b1
  } osl_reg_t;

  localparam logic [RANGE_BITS-1:0] STOP_RESET = RANGE_BITS'(300);
  localparam logic [RANGE_BITS-1:0] SLOW_RESET = RANGE_BITS'(800);

  typedef struct packed {
    logic                       snapshot_valid;
    logic [RANGE_BITS-1:0]      range_left_mm;
    logic [RANGE_BITS-1:0]      range_center_mm;
    logic [RANGE_BITS-1:0]      range_right_mm;
    logic signed [CMD_BITS-1:0] forward_cmd;
    logic signed [CMD_BITS-1:0] turn_cmd;
  } osl_in_t;

  typedef struct packed {
    logic signed [CMD_BITS-1:0] forward_out;
    logic signed [CMD_BITS-1:0] turn_out;
    logic [RANGE_BITS-1:0]      nearest_mm;
    logic                       stop_flag;
    logic [SCALE_BITS-1:0]      speed_scale;
  } osl_out_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] stop_mm;
    logic [RANGE_BITS-1:0] slow_mm;
  } osl_cfg_t;

  // per-item data riding alongside the divider
  typedef struct packed {
    logic [RANGE_BITS-1:0]      nearest;
    logic                       stop;
    logic                       slow;
    logic signed [CMD_BITS-1:0] fwd;
    logic signed [CMD_BITS-1:0] turn;
  } osl_side_t;

endpackage

[design/osl_front.sv]
module osl_front import osl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  osl_in_t               in_data,
  input  osl_cfg_t              cfg,
  output logic                  out_valid,
  output logic [RANGE_BITS-1:0] out_diff,
  output logic [RANGE_BITS-1:0] out_span,
  output osl_side_t             out_side
);

  logic [RANGE_BITS:0]   key_l, key_c, key_r, key_lc, key_min;
  logic [RANGE_BITS-1:0] nearest;
  logic                  fwd_pos, limit;
  logic                  valid_r;
  logic [RANGE_BITS-1:0] diff_r, diff_nxt;
  logic [RANGE_BITS-1:0] span_r, span_nxt;
  osl_side_t             side_r, side_nxt;

  // a missing reading sorts above every real one and reads back as zero
  assign key_l   = {in_data.range_left_mm == '0, in_data.range_left_mm};
  assign key_c   = {in_data.range_center_mm == '0, in_data.range_center_mm};
  assign key_r   = {in_data.range_right_mm == '0, in_data.range_right_mm};
  assign key_lc  = (key_c < key_l) ? key_c : key_l;
  assign key_min = (key_r < key_lc) ? key_r : key_lc;

  always_comb begin
    nearest  = in_data.snapshot_valid ? key_min[RANGE_BITS-1:0] : '0;
    fwd_pos  = !in_data.forward_cmd[CMD_BITS-1] && (in_data.forward_cmd != '0);
    limit    = (nearest != '0) && fwd_pos;
    diff_nxt = nearest - cfg.stop_mm;
    span_nxt = (cfg.slow_mm > cfg.stop_mm) ? (cfg.slow_mm - cfg.stop_mm)
                                           : RANGE_BITS'(1);
    side_nxt.nearest = nearest;
    side_nxt.stop    = limit && (nearest <= cfg.stop_mm);
    side_nxt.slow    = limit && (nearest > cfg.stop_mm) && (nearest < cfg.slow_mm);
    side_nxt.fwd     = in_data.forward_cmd;
    side_nxt.turn    = in_data.turn_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    span_r <= span_nxt;
    side_r <= side_nxt;
  end

  assign out_valid = valid_r;
  assign out_diff  = diff_r;
  assign out_span  = span_r;
  assign out_side  = side_r;

endmodule

[design/osl_div.sv]
module osl_div import osl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [RANGE_BITS-1:0] in_rem,
  input  logic [RANGE_BITS-1:0] in_span,
  input  osl_side_t             in_side,
  output logic                  out_valid,
  output logic [QUO_BITS-1:0]   out_quo,
  output osl_side_t             out_side
);

  // restoring divide of (rem << QUO_BITS) by span, DIV_STEPS quotient bits per stage;
  // rem < span holds for slow items, whose quotient is used; it fits without a clamp
  logic                  vld_in  [DIV_STAGES];
  logic [RANGE_BITS-1:0] rem_in  [DIV_STAGES];
  logic [QUO_BITS-1:0]   quo_in  [DIV_STAGES];
  logic [RANGE_BITS-1:0] span_in [DIV_STAGES];
  osl_side_t             side_in [DIV_STAGES];

  logic                  vld_r  [DIV_STAGES];
  logic [RANGE_BITS-1:0] rem_r  [DIV_STAGES];
  logic [QUO_BITS-1:0]   quo_r  [DIV_STAGES];
  logic [RANGE_BITS-1:0] span_r [DIV_STAGES];
  osl_side_t             side_r [DIV_STAGES];

  logic [RANGE_BITS-1:0] rem_nxt [DIV_STAGES];
  logic [QUO_BITS-1:0]   quo_nxt [DIV_STAGES];

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
        assign vld_in[k]  = in_valid;
        assign rem_in[k]  = in_rem;
        assign quo_in[k]  = '0;
        assign span_in[k] = in_span;
        assign side_in[k] = in_side;
      end else begin : g_next
        assign vld_in[k]  = vld_r[k-1];
        assign rem_in[k]  = rem_r[k-1];
        assign quo_in[k]  = quo_r[k-1];
        assign span_in[k] = span_r[k-1];
        assign side_in[k] = side_r[k-1];
      end

      always_comb begin
        logic [REM_BITS-1:0]   trial;
        logic [RANGE_BITS-1:0] r;
        logic [QUO_BITS-1:0]   q;
        r = rem_in[k];
        q = quo_in[k];
        for (int j = 0; j < DIV_STEPS; j++) begin
          trial = {r, 1'b0};
          if (trial >= {1'b0, span_in[k]}) begin
            trial = trial - {1'b0, span_in[k]};
            q = {q[QUO_BITS-2:0], 1'b1};
          end else begin
            q = {q[QUO_BITS-2:0], 1'b0};
          end
          r = trial[RANGE_BITS-1:0];
        end
        rem_nxt[k] = r;
        quo_nxt[k] = q;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= vld_in[k];
        end
      end

      always_ff @(posedge clk) begin
        rem_r[k]  <= rem_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        span_r[k] <= span_in[k];
        side_r[k] <= side_in[k];
      end
    end
  endgenerate

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_quo   = quo_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

[design/osl_mul.sv]
module osl_mul import osl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [QUO_BITS-1:0] in_quo,
  input  osl_side_t           in_side,
  output logic                out_valid,
  output osl_out_t            out_data
);

  logic                vld_a_r;
  logic [MUL_BITS-1:0] prod_a_r, prod_a_nxt;
  logic [QUO_BITS-1:0] quo_a_r;
  osl_side_t           side_a_r;

  logic                vld_b_r;
  osl_out_t            out_r, out_nxt;

  // forward is known positive whenever the product is used
  assign prod_a_nxt = MUL_BITS'(in_side.fwd[CMD_BITS-2:0]) * MUL_BITS'(in_quo);

  always_comb begin
    out_nxt.turn_out   = side_a_r.turn;
    out_nxt.nearest_mm = side_a_r.nearest;
    out_nxt.stop_flag  = side_a_r.stop;
    if (side_a_r.stop) begin
      out_nxt.forward_out = '0;
      out_nxt.speed_scale = '0;
    end else if (side_a_r.slow) begin
      out_nxt.forward_out = {1'b0, prod_a_r[MUL_BITS-1:QUO_BITS]};
      out_nxt.speed_scale = {1'b0, quo_a_r};
    end else begin
      out_nxt.forward_out = side_a_r.fwd;
      out_nxt.speed_scale = SCALE_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_a_r <= prod_a_nxt;
    quo_a_r  <= in_quo;
    side_a_r <= in_side;
    out_r    <= out_nxt;
  end

  assign out_valid = vld_b_r;
  assign out_data  = out_r;

endmodule

[design/obstacle_speed_limiter_core.sv]
// channel   direction  handshake                     payload
// input     in         start / busy                  in_data   (osl_in_t)
// result    out        out_valid strobe, one cycle   out_data  (osl_out_t)
// config    in / out   psel penable pwrite pready    paddr pwdata prdata
//
// one beat per cycle in, one result per beat out, in order through the pipeline:
// front stage, five divider stages of three quotient bits, multiply, output register
// busy is high only while rst_n is low; reset clears the pipeline valids and
// restores stop 300 mm / slow 800 mm
// the receiver cannot stall, so the pipeline never holds
`include "assert_macros.svh"

module obstacle_speed_limiter_core import osl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  osl_in_t                  in_data,
  output logic                     out_valid,
  output osl_out_t                 out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [RANGE_BITS-1:0] stop_r, slow_r;
  logic                  cfg_wr;
  osl_reg_t              cfg_sel;
  osl_cfg_t              cfg;
  logic                  accept;

  logic                  f_valid;
  logic [RANGE_BITS-1:0] f_diff, f_span;
  osl_side_t             f_side;
  logic                  d_valid;
  logic [QUO_BITS-1:0]   d_quo;
  osl_side_t             d_side;

  assign busy   = !rst_n;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_sel = osl_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= STOP_RESET;
      slow_r <= SLOW_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_STOP_DIST: stop_r <= pwdata[RANGE_BITS-1:0];
        REG_SLOW_DIST: slow_r <= pwdata[RANGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_STOP_DIST: prdata = CFG_DATA_BITS'(stop_r);
      REG_SLOW_DIST: prdata = CFG_DATA_BITS'(slow_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.stop_mm = stop_r;
  assign cfg.slow_mm = slow_r;

  osl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out_diff  (f_diff),
    .out_span  (f_span),
    .out_side  (f_side)
  );

  osl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_rem    (f_diff),
    .in_span   (f_span),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_side  (d_side)
  );

  osl_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_quo    (d_quo),
    .in_side   (d_side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // every accepted beat comes out, and out_valid rises for no other beat
  `ASSERT_ALWAYS(a_latency, clk, rst_n, out_valid == ($past(accept, LATENCY) === 1'b1))
  `ASSERT_IMP(a_stop_zero, clk, rst_n, out_valid && out_data.stop_flag,
              out_data.forward_out == '0 && out_data.speed_scale == '0 &&
              out_data.nearest_mm != '0)
  `ASSERT_IMP(a_none_full, clk, rst_n, out_valid && out_data.nearest_mm == '0,
              out_data.speed_scale == SCALE_ONE && !out_data.stop_flag)
  `ASSERT_IMP(a_scale_cap, clk, rst_n, out_valid,
              out_data.speed_scale <= SCALE_ONE)

endmodule
